// ===== rtl/core/hid_mouse_report_to_events_defines.svh =====
// assertion macros for the mouse report event generator
// used by the port checker; needs clk and rst_n in scope at the point of use
`ifndef HID_MOUSE_REPORT_TO_EVENTS_DEFINES_SVH
`define HID_MOUSE_REPORT_TO_EVENTS_DEFINES_SVH

// property checked only outside reset
`define HMRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define HMRE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hmre_pkg.sv =====
// shared constants and types for the mouse report event generator
// no dependencies; imported by every module of the block
`default_nettype none

package hmre_pkg;

  // button configuration, capped to the width of the button state
  localparam int BUTTON_COUNT = 8;
  localparam int BTN_W        = 8;
  localparam int BTN_EFF      = (BUTTON_COUNT > BTN_W) ? BTN_W : BUTTON_COUNT;

  // item operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_REL   = 2'd1;
  localparam logic [1:0] OP_ABS   = 2'd2;
  localparam logic [1:0] OP_END   = 2'd3;

  // usage pages and usages
  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
  localparam logic [15:0] USAGE_X      = 16'h0030;
  localparam logic [15:0] USAGE_Y      = 16'h0031;
  localparam logic [15:0] USAGE_WHEEL  = 16'h0038;

  // event kinds
  localparam logic [1:0] KIND_ABS    = 2'd0;
  localparam logic [1:0] KIND_REL    = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;
  localparam logic [1:0] KIND_BUTTON = 2'd3;

  // emission steps of one end of report, in output order
  localparam int STEP_ABS    = 0;
  localparam int STEP_REL    = 1;
  localparam int STEP_SCROLL = 2;
  localparam int STEP_BTN0   = 3;
  localparam int STEP_N      = STEP_BTN0 + BTN_W;
  localparam int STEP_W      = $clog2(STEP_N);

  // command queue depth
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

  // snapshot of report state taken at end of report
  typedef struct packed {
    logic [31:0]       abs_x_pos;
    logic [31:0]       abs_x_low;
    logic [31:0]       abs_x_high;
    logic [31:0]       abs_y_pos;
    logic [31:0]       abs_y_low;
    logic [31:0]       abs_y_high;
    logic [31:0]       rel_x;
    logic [31:0]       rel_y;
    logic [31:0]       wheel;
    logic [BTN_W-1:0]  buttons;
    logic [STEP_N-1:0] steps;
  } snap_t;

  // one output event
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic [31:0] x_low;
    logic [31:0] x_high;
    logic [31:0] y_low;
    logic [31:0] y_high;
    logic [31:0] scroll;
    logic [2:0]  btn_idx;
    logic        btn_pressed;
    logic        last;
  } event_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hmre_cmdq.sv =====
// short command queue between the front and the back of the event generator
// depends on hmre_pkg for the snapshot type and the queue depth
`default_nettype none

module hmre_cmdq import hmre_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire snap_t  push_data,
  input  wire logic   pop,
  output snap_t       pop_data,
  output qstat_t      stat
);

  snap_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r, count_nxt;
  logic                do_push, do_pop;

  // status
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmre_front.sv =====
// front of the event generator: accepts items and keeps the report state
// depends on hmre_pkg; pushes an end-of-report snapshot into hmre_cmdq
`default_nettype none

module hmre_front import hmre_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_usage_page,
  input  wire logic [15:0] in_usage_id,
  input  wire logic [31:0] in_field_value,
  input  wire logic [31:0] in_field_min,
  input  wire logic [31:0] in_field_max,
  input  wire qstat_t      q_stat,
  output logic             q_push,
  output snap_t            q_data
);

  logic [31:0]      rel_x_r, rel_x_nxt;
  logic [31:0]      rel_y_r, rel_y_nxt;
  logic [31:0]      wheel_r, wheel_nxt;
  logic [31:0]      ax_pos_r, ax_pos_nxt, ax_low_r, ax_low_nxt, ax_high_r, ax_high_nxt;
  logic [31:0]      ay_pos_r, ay_pos_nxt, ay_low_r, ay_low_nxt, ay_high_r, ay_high_nxt;
  logic             ax_seen_r, ax_seen_nxt;
  logic             ay_seen_r, ay_seen_nxt;
  logic [BTN_W-1:0] btn_rep_r, btn_rep_nxt;
  logic [BTN_W-1:0] btn_pend_r, btn_pend_nxt;
  logic             accept;
  logic             is_desktop, is_button, btn_ok;
  logic [2:0]       btn_bit;
  logic [BTN_W-1:0] btn_changed;

  assign in_full    = q_stat.full;
  assign accept     = in_push && !q_stat.full;
  assign is_desktop = (in_usage_page == PAGE_DESKTOP);
  assign is_button  = (in_usage_page == PAGE_BUTTON);
  assign btn_ok     = (in_usage_id != '0) && (in_usage_id <= 16'(BTN_EFF));
  assign btn_bit    = in_usage_id[2:0] - 3'd1;
  assign btn_changed = btn_rep_r ^ btn_pend_r;

  // snapshot of the state as it stands when end of report arrives
  always_comb begin
    q_data.abs_x_pos  = ax_pos_r;
    q_data.abs_x_low  = ax_low_r;
    q_data.abs_x_high = ax_high_r;
    q_data.abs_y_pos  = ay_pos_r;
    q_data.abs_y_low  = ay_low_r;
    q_data.abs_y_high = ay_high_r;
    q_data.rel_x      = rel_x_r;
    q_data.rel_y      = rel_y_r;
    q_data.wheel      = wheel_r;
    q_data.buttons    = btn_pend_r;
    q_data.steps      = '0;
    q_data.steps[STEP_ABS]    = ax_seen_r && ay_seen_r;
    q_data.steps[STEP_REL]    = (rel_x_r != '0) || (rel_y_r != '0);
    q_data.steps[STEP_SCROLL] = (wheel_r != '0);
    q_data.steps[STEP_N-1:STEP_BTN0] = btn_changed;
  end

  // only reports that produce events go to the back
  assign q_push = accept && (in_operation == OP_END) && (q_data.steps != '0);

  // state update per accepted item
  always_comb begin
    rel_x_nxt   = rel_x_r;
    rel_y_nxt   = rel_y_r;
    wheel_nxt   = wheel_r;
    ax_pos_nxt  = ax_pos_r;
    ax_low_nxt  = ax_low_r;
    ax_high_nxt = ax_high_r;
    ay_pos_nxt  = ay_pos_r;
    ay_low_nxt  = ay_low_r;
    ay_high_nxt = ay_high_r;
    ax_seen_nxt = ax_seen_r;
    ay_seen_nxt = ay_seen_r;
    btn_rep_nxt = btn_rep_r;
    btn_pend_nxt = btn_pend_r;
    if (accept) begin
      case (in_operation)
        OP_START: begin
          rel_x_nxt    = '0;
          rel_y_nxt    = '0;
          wheel_nxt    = '0;
          ax_seen_nxt  = 1'b0;
          ay_seen_nxt  = 1'b0;
          btn_pend_nxt = '0;
        end
        OP_REL: begin
          if (is_desktop) begin
            if (in_usage_id == USAGE_X) begin
              rel_x_nxt = in_field_value;
            end else if (in_usage_id == USAGE_Y) begin
              rel_y_nxt = in_field_value;
            end else if (in_usage_id == USAGE_WHEEL) begin
              wheel_nxt = in_field_value;
            end
          end
        end
        OP_ABS: begin
          if (is_desktop) begin
            if (in_usage_id == USAGE_X) begin
              ax_pos_nxt  = in_field_value;
              ax_low_nxt  = in_field_min;
              ax_high_nxt = in_field_max;
              ax_seen_nxt = 1'b1;
            end else if (in_usage_id == USAGE_Y) begin
              ay_pos_nxt  = in_field_value;
              ay_low_nxt  = in_field_min;
              ay_high_nxt = in_field_max;
              ay_seen_nxt = 1'b1;
            end
          end else if (is_button && btn_ok) begin
            btn_pend_nxt[btn_bit] = (in_field_value != '0);
          end
        end
        OP_END: begin
          btn_rep_nxt = btn_pend_r;
        end
        default: begin
          btn_rep_nxt = btn_rep_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_x_r    <= '0;
      rel_y_r    <= '0;
      wheel_r    <= '0;
      ax_pos_r   <= '0;
      ax_low_r   <= '0;
      ax_high_r  <= '0;
      ay_pos_r   <= '0;
      ay_low_r   <= '0;
      ay_high_r  <= '0;
      ax_seen_r  <= 1'b0;
      ay_seen_r  <= 1'b0;
      btn_rep_r  <= '0;
      btn_pend_r <= '0;
    end else begin
      rel_x_r    <= rel_x_nxt;
      rel_y_r    <= rel_y_nxt;
      wheel_r    <= wheel_nxt;
      ax_pos_r   <= ax_pos_nxt;
      ax_low_r   <= ax_low_nxt;
      ax_high_r  <= ax_high_nxt;
      ay_pos_r   <= ay_pos_nxt;
      ay_low_r   <= ay_low_nxt;
      ay_high_r  <= ay_high_nxt;
      ax_seen_r  <= ax_seen_nxt;
      ay_seen_r  <= ay_seen_nxt;
      btn_rep_r  <= btn_rep_nxt;
      btn_pend_r <= btn_pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hmre_back.sv =====
// back of the event generator: walks one snapshot and emits its events
// depends on hmre_pkg; pops hmre_cmdq and holds the output register
`default_nettype none

module hmre_back import hmre_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire qstat_t q_stat,
  input  wire snap_t  q_data,
  output logic        q_pop,
  output logic        out_empty,
  input  wire logic   out_pop,
  output event_t      out_ev
);

  snap_t             cur_r;
  logic [STEP_N-1:0] mask_r, mask_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  event_t            out_ev_r;
  event_t            ev;
  logic [STEP_W-1:0] sel;
  logic [STEP_N-1:0] mask_rest;
  logic [2:0]        bidx;
  logic [31:0]       neg_y;
  logic              out_free, emit, load;

  assign out_free  = !out_valid_r || out_pop;
  assign emit      = busy_r && out_free;
  assign load      = !busy_r && !q_stat.empty;
  assign q_pop     = load;
  assign out_empty = !out_valid_r;
  assign out_ev    = out_ev_r;

  // lowest pending step
  always_comb begin
    sel = '0;
    for (int i = STEP_N - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = STEP_W'(i);
      end
    end
  end

  assign mask_rest = mask_r & ~(STEP_N'(1) << sel);
  assign bidx      = 3'(sel - STEP_W'(STEP_BTN0));
  assign neg_y     = (cur_r.rel_y == INT_MIN) ? INT_MAX : (32'd0 - cur_r.rel_y);

  // event for the selected step, unused fields zero
  always_comb begin
    ev      = '0;
    ev.last = (mask_rest == '0);
    case (sel)
      STEP_W'(STEP_ABS): begin
        ev.kind    = KIND_ABS;
        ev.x_value = cur_r.abs_x_pos;
        ev.y_value = cur_r.abs_y_pos;
        ev.x_low   = cur_r.abs_x_low;
        ev.x_high  = cur_r.abs_x_high;
        ev.y_low   = cur_r.abs_y_low;
        ev.y_high  = cur_r.abs_y_high;
      end
      STEP_W'(STEP_REL): begin
        ev.kind    = KIND_REL;
        ev.x_value = cur_r.rel_x;
        ev.y_value = neg_y;
      end
      STEP_W'(STEP_SCROLL): begin
        ev.kind   = KIND_SCROLL;
        ev.scroll = cur_r.wheel;
      end
      default: begin
        ev.kind        = KIND_BUTTON;
        ev.btn_idx     = bidx;
        ev.btn_pressed = cur_r.buttons[bidx];
      end
    endcase
  end

  // control of the walk and the output register
  always_comb begin
    mask_nxt      = mask_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      mask_nxt = q_data.steps;
      busy_nxt = 1'b1;
    end else if (emit) begin
      mask_nxt      = mask_rest;
      busy_nxt      = (mask_rest != '0);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
    if (emit) begin
      out_ev_r <= ev;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hid_mouse_report_to_events.sv =====
// top level of the mouse report event generator
// depends on hmre_pkg, hmre_front, hmre_cmdq and hmre_back
//
// channel  | handshake     | payload
// input    | in_push/full  | operation, usage page/id, value, logical min/max
// result   | out_pop/empty | event kind, positions, bounds, scroll, button, last
//
// the front takes items while in_full is low and stalls only when the
// two-entry command queue is full of pending end-of-report snapshots.
// the back loads a snapshot, then emits its events in step order while the
// output register is free; it loads the next snapshot after the last event.
// the output register frees up in the cycle it is popped.
// reset is synchronous; after it all deltas, flags and buttons are zero.
`default_nettype none

module hid_mouse_report_to_events import hmre_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic        [1:0]  in_operation,
  input  wire logic        [15:0] in_usage_page,
  input  wire logic        [15:0] in_usage_id,
  input  wire logic signed [31:0] in_field_value,
  input  wire logic signed [31:0] in_field_min,
  input  wire logic signed [31:0] in_field_max,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic             [1:0]  out_event_kind,
  output logic signed      [31:0] out_x_value,
  output logic signed      [31:0] out_y_value,
  output logic signed      [31:0] out_x_low_bound,
  output logic signed      [31:0] out_x_high_bound,
  output logic signed      [31:0] out_y_low_bound,
  output logic signed      [31:0] out_y_high_bound,
  output logic signed      [31:0] out_scroll_amount,
  output logic             [2:0]  out_button_index,
  output logic                    out_button_pressed,
  output logic                    out_last_event
);

  qstat_t q_stat;
  logic   q_push, q_pop;
  snap_t  q_in, q_out;
  event_t ev;

  // item intake and report state
  hmre_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_usage_page  (in_usage_page),
    .in_usage_id    (in_usage_id),
    .in_field_value (in_field_value),
    .in_field_min   (in_field_min),
    .in_field_max   (in_field_max),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  // snapshot queue
  hmre_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // event emission
  hmre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_ev    (ev)
  );

  // result ports
  assign out_event_kind     = ev.kind;
  assign out_x_value        = ev.x_value;
  assign out_y_value        = ev.y_value;
  assign out_x_low_bound    = ev.x_low;
  assign out_x_high_bound   = ev.x_high;
  assign out_y_low_bound    = ev.y_low;
  assign out_y_high_bound   = ev.y_high;
  assign out_scroll_amount  = ev.scroll;
  assign out_button_index   = ev.btn_idx;
  assign out_button_pressed = ev.btn_pressed;
  assign out_last_event     = ev.last;

endmodule

`default_nettype wire

// ===== rtl/core/hmre_checker.sv =====
// port checker for the mouse report event generator, bound to the top level
// depends on hmre_pkg and hid_mouse_report_to_events_defines.svh
`default_nettype none
`include "hid_mouse_report_to_events_defines.svh"

module hmre_checker import hmre_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire logic        [1:0]  in_operation,
  input wire logic        [15:0] in_usage_page,
  input wire logic        [15:0] in_usage_id,
  input wire logic signed [31:0] in_field_value,
  input wire logic signed [31:0] in_field_min,
  input wire logic signed [31:0] in_field_max,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic        [1:0]  out_event_kind,
  input wire logic signed [31:0] out_x_value,
  input wire logic signed [31:0] out_y_value,
  input wire logic signed [31:0] out_x_low_bound,
  input wire logic signed [31:0] out_x_high_bound,
  input wire logic signed [31:0] out_y_low_bound,
  input wire logic signed [31:0] out_y_high_bound,
  input wire logic signed [31:0] out_scroll_amount,
  input wire logic        [2:0]  out_button_index,
  input wire logic               out_button_pressed,
  input wire logic               out_last_event
);

  // a waiting item holds until popped
  `HMRE_ASSERT(a_out_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_event_kind) && $stable(out_x_value) && $stable(out_last_event), "result changed while stalled")

  // reset leaves both queues open and empty
  `HMRE_ASSERT_RST(a_reset_clear, !rst_n |=> out_empty && !in_full, "not empty after reset")

  // relative y is negated with saturation, never the most negative value
  `HMRE_ASSERT(a_rel_y_sat, !out_empty && out_event_kind == KIND_REL |-> out_y_value != $signed(INT_MIN), "unsaturated y")

  // scroll events carry a wheel delta and nothing else
  `HMRE_ASSERT(a_scroll_only, !out_empty && out_event_kind == KIND_SCROLL |-> out_scroll_amount != 0 && out_x_value == 0 && out_button_pressed == 1'b0, "bad scroll item")

endmodule

bind hid_mouse_report_to_events hmre_checker u_hmre_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for hid_mouse_report_to_events
// needs hmre_pkg and the block's rtl; drives report items, predicts events, checks results
`timescale 1ns / 1ps

module tb_top;
  import hmre_pkg::*;

  localparam int RANDOM_ITEMS   = 230;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int MAX_REPORTS    = 40;

  // one report item as driven on the input ports
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] page;
    logic [15:0] usage;
    logic [31:0] value;
    logic [31:0] lo;
    logic [31:0] hi;
  } report_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic        [1:0]  in_operation = OP_START;
  logic        [15:0] in_usage_page = '0;
  logic        [15:0] in_usage_id = '0;
  logic signed [31:0] in_field_value = '0;
  logic signed [31:0] in_field_min = '0;
  logic signed [31:0] in_field_max = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic        [1:0]  out_event_kind;
  logic signed [31:0] out_x_value;
  logic signed [31:0] out_y_value;
  logic signed [31:0] out_x_low_bound;
  logic signed [31:0] out_x_high_bound;
  logic signed [31:0] out_y_low_bound;
  logic signed [31:0] out_y_high_bound;
  logic signed [31:0] out_scroll_amount;
  logic        [2:0]  out_button_index;
  logic               out_button_pressed;
  logic               out_last_event;

  hid_mouse_report_to_events dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_operation       (in_operation),
    .in_usage_page      (in_usage_page),
    .in_usage_id        (in_usage_id),
    .in_field_value     (in_field_value),
    .in_field_min       (in_field_min),
    .in_field_max       (in_field_max),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_event_kind     (out_event_kind),
    .out_x_value        (out_x_value),
    .out_y_value        (out_y_value),
    .out_x_low_bound    (out_x_low_bound),
    .out_x_high_bound   (out_x_high_bound),
    .out_y_low_bound    (out_y_low_bound),
    .out_y_high_bound   (out_y_high_bound),
    .out_scroll_amount  (out_scroll_amount),
    .out_button_index   (out_button_index),
    .out_button_pressed (out_button_pressed),
    .out_last_event     (out_last_event)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  report_item_t report_items[$];
  event_t       expected_events[$];

  int useful_items   = 0;
  int items_accepted = 0;
  int ends_accepted  = 0;
  int events_checked = 0;
  int mismatches     = 0;
  int full_stalls    = 0;
  int events_by_kind[4];

  // mirror of the block's report state
  logic [31:0]      m_rel_x, m_rel_y, m_wheel;
  logic [31:0]      m_abs_x, m_abs_x_lo, m_abs_x_hi;
  logic [31:0]      m_abs_y, m_abs_y_lo, m_abs_y_hi;
  logic             m_x_seen, m_y_seen;
  logic [BTN_W-1:0] m_btn_reported, m_btn_pending;

  task automatic clear_mouse_state();
    m_rel_x = '0; m_rel_y = '0; m_wheel = '0;
    m_abs_x = '0; m_abs_x_lo = '0; m_abs_x_hi = '0;
    m_abs_y = '0; m_abs_y_lo = '0; m_abs_y_hi = '0;
    m_x_seen = 1'b0; m_y_seen = 1'b0;
    m_btn_reported = '0; m_btn_pending = '0;
  endtask

  // update the mirror with one accepted item and queue the events it causes
  task automatic predict_mouse_events(input report_item_t it);
    event_t ev;
    int     first;
    first = expected_events.size();
    case (it.op)
      OP_START: begin
        m_rel_x = '0; m_rel_y = '0; m_wheel = '0;
        m_x_seen = 1'b0; m_y_seen = 1'b0;
        m_btn_pending = '0;
      end
      OP_REL: begin
        if (it.page == PAGE_DESKTOP) begin
          if (it.usage == USAGE_X) m_rel_x = it.value;
          else if (it.usage == USAGE_Y) m_rel_y = it.value;
          else if (it.usage == USAGE_WHEEL) m_wheel = it.value;
        end
      end
      OP_ABS: begin
        if (it.page == PAGE_DESKTOP && it.usage == USAGE_X) begin
          m_abs_x = it.value; m_abs_x_lo = it.lo; m_abs_x_hi = it.hi; m_x_seen = 1'b1;
        end else if (it.page == PAGE_DESKTOP && it.usage == USAGE_Y) begin
          m_abs_y = it.value; m_abs_y_lo = it.lo; m_abs_y_hi = it.hi; m_y_seen = 1'b1;
        end else if (it.page == PAGE_BUTTON && it.usage != 0 && it.usage <= BTN_EFF) begin
          m_btn_pending[3'(it.usage - 16'd1)] = (it.value != 0);
        end
      end
      default: begin
        // end of report: moves, scroll, then changed buttons in index order
        if (m_x_seen && m_y_seen) begin
          ev = '0;
          ev.kind = KIND_ABS;
          ev.x_value = m_abs_x; ev.y_value = m_abs_y;
          ev.x_low = m_abs_x_lo; ev.x_high = m_abs_x_hi;
          ev.y_low = m_abs_y_lo; ev.y_high = m_abs_y_hi;
          expected_events.push_back(ev);
        end
        if (m_rel_x != 0 || m_rel_y != 0) begin
          ev = '0;
          ev.kind = KIND_REL;
          ev.x_value = m_rel_x;
          ev.y_value = (m_rel_y == INT_MIN) ? INT_MAX : -m_rel_y;
          expected_events.push_back(ev);
        end
        if (m_wheel != 0) begin
          ev = '0;
          ev.kind = KIND_SCROLL;
          ev.scroll = m_wheel;
          expected_events.push_back(ev);
        end
        for (int i = 0; i < BTN_EFF; i++) begin
          if (m_btn_reported[i] != m_btn_pending[i]) begin
            ev = '0;
            ev.kind = KIND_BUTTON;
            ev.btn_idx = i[2:0];
            ev.btn_pressed = m_btn_pending[i];
            expected_events.push_back(ev);
          end
        end
        m_btn_reported = m_btn_pending;
        if (expected_events.size() > first)
          expected_events[expected_events.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // stimulus helpers
  task automatic add_item(input logic [1:0] op, input logic [15:0] page, usage,
                          input logic [31:0] value, lo, hi);
    report_item_t it;
    logic         known;
    it = '{op: op, page: page, usage: usage, value: value, lo: lo, hi: hi};
    known = (op == OP_START) || (op == OP_END) ||
            (page == PAGE_DESKTOP && (usage == USAGE_X || usage == USAGE_Y)) ||
            (op == OP_REL && page == PAGE_DESKTOP && usage == USAGE_WHEEL) ||
            (op == OP_ABS && page == PAGE_BUTTON && usage != 0 && usage <= BTN_EFF);
    if (known) useful_items++;
    report_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9))
      0: return '0;
      1: return INT_MIN;
      2: return INT_MAX;
      3: return '1;
      4, 5: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  // one field item, mostly on usages that the block keeps
  task automatic add_random_field();
    logic [15:0] btn;
    case ($urandom_range(9))
      0: add_item(OP_REL, PAGE_DESKTOP, USAGE_X, rand_value(), $urandom, $urandom);
      1: add_item(OP_REL, PAGE_DESKTOP, USAGE_Y, rand_value(), $urandom, $urandom);
      2: add_item(OP_REL, PAGE_DESKTOP, USAGE_WHEEL, rand_value(), $urandom, $urandom);
      3: add_item(OP_ABS, PAGE_DESKTOP, USAGE_X, rand_value(), rand_value(), rand_value());
      4: add_item(OP_ABS, PAGE_DESKTOP, USAGE_Y, rand_value(), rand_value(), rand_value());
      5, 6, 7: begin
        // mostly valid buttons, sometimes button 0 or past the last one
        case ($urandom_range(9))
          0: btn = 16'd0;
          1: btn = 16'($urandom_range(BTN_EFF + 4, BTN_EFF + 1));
          2: btn = 16'($urandom);
          default: btn = 16'($urandom_range(BTN_EFF, 1));
        endcase
        add_item(OP_ABS, PAGE_BUTTON, btn, ($urandom_range(2) == 0) ? 32'd0 : rand_value(),
                 $urandom, $urandom);
      end
      8: add_item(OP_REL, PAGE_BUTTON, 16'($urandom_range(BTN_EFF, 1)), rand_value(),
                  '0, '0);
      default: add_item(2'($urandom_range(OP_ABS, OP_REL)), 16'($urandom), 16'($urandom),
                        $urandom, $urandom, $urandom);
    endcase
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // input driver: holds each item until the block takes it
  report_item_t cur_item;
  int           send_gap = 0;

  always @(posedge clk) begin : driver
    logic next_push;
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
    end else begin
      next_push = in_push;
      if (in_push && in_full) full_stalls++;
      if (in_push && !in_full) begin
        predict_mouse_events(cur_item);
        items_accepted++;
        if (cur_item.op == OP_END) ends_accepted++;
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (report_items.size() > 0) begin
          cur_item = report_items.pop_front();
          in_operation   <= cur_item.op;
          in_usage_page  <= cur_item.page;
          in_usage_id    <= cur_item.usage;
          in_field_value <= cur_item.value;
          in_field_min   <= cur_item.lo;
          in_field_max   <= cur_item.hi;
          next_push = 1'b1;
          send_gap = pick_gap((items_accepted / 40) % 4 == 1);
        end
      end
      in_push <= next_push;
    end
  end

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, $signed(want), $signed(got));
    end
  endtask

  // result monitor with random pops and one long hold-off
  int pop_gap   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : monitor
    event_t want;
    logic   next_pop;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected event, expected none, actual kind %0d",
                     $time, out_event_kind);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 32'(want.kind), 32'(out_event_kind));
          check_field("x_value", want.x_value, out_x_value);
          check_field("y_value", want.y_value, out_y_value);
          check_field("x_low_bound", want.x_low, out_x_low_bound);
          check_field("x_high_bound", want.x_high, out_x_high_bound);
          check_field("y_low_bound", want.y_low, out_y_low_bound);
          check_field("y_high_bound", want.y_high, out_y_high_bound);
          check_field("scroll_amount", want.scroll, out_scroll_amount);
          check_field("button_index", 32'(want.btn_idx), 32'(out_button_index));
          check_field("button_pressed", 32'(want.btn_pressed), 32'(out_button_pressed));
          check_field("last_event", 32'(want.last), 32'(out_last_event));
        end
        events_checked++;
        events_by_kind[out_event_kind]++;
        pop_gap = pick_gap((events_checked / 25) % 4 == 1);
      end
      // stop popping for a long stretch once so the block backs up
      if (!hold_done && events_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      next_pop = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        next_pop = 1'b0;
      end
      out_pop <= next_pop;
    end
  end

  // watchdog on handshake activity
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d events outstanding",
               $time, idle_cycles, expected_events.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin : sequencer
    int n;
    clear_mouse_state();

    // directed: empty end after reset, extremes, ignored usages, repeat end
    add_item(OP_END, '0, '0, '0, '0, '0);
    add_item(OP_START, '0, '0, '0, '0, '0);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_X, INT_MAX, '0, '0);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_Y, INT_MIN, '0, '0);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_WHEEL, '1, '0, '0);
    add_item(OP_ABS, PAGE_DESKTOP, USAGE_X, INT_MIN, INT_MIN, INT_MAX);
    add_item(OP_ABS, PAGE_DESKTOP, USAGE_Y, INT_MAX, 32'd0, 32'd32767);
    add_item(OP_ABS, PAGE_BUTTON, 16'd1, 32'd1, '0, '0);
    add_item(OP_ABS, PAGE_BUTTON, 16'(BTN_EFF), INT_MIN, '0, '0);
    add_item(OP_ABS, PAGE_BUTTON, 16'd0, 32'd1, '0, '0);
    add_item(OP_ABS, PAGE_BUTTON, 16'(BTN_EFF + 1), 32'd1, '0, '0);
    add_item(OP_REL, PAGE_BUTTON, 16'd2, 32'd1, '0, '0);
    add_item(OP_ABS, 16'hffff, 16'hffff, '1, '1, '1);
    add_item(OP_REL, PAGE_DESKTOP, 16'h0032, 32'd5, '0, '0);
    add_item(OP_END, '0, '0, '0, '0, '0);
    add_item(OP_END, 16'hffff, 16'hffff, '1, '1, '1);
    // overwrite, one absolute axis only, button release
    add_item(OP_START, 16'hffff, 16'hffff, '1, '1, '1);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_X, 32'd5, '0, '0);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_X, 32'd0, '0, '0);
    add_item(OP_REL, PAGE_DESKTOP, USAGE_Y, 32'd7, '0, '0);
    add_item(OP_ABS, PAGE_BUTTON, 16'd1, 32'd0, '0, '0);
    add_item(OP_ABS, PAGE_DESKTOP, USAGE_X, 32'd100, 32'd0, 32'd1000);
    add_item(OP_ABS, PAGE_BUTTON, 16'd3, 32'd2, '0, '0);
    add_item(OP_END, '0, '0, '0, '0, '0);
    add_item(OP_START, '0, '0, '0, '0, '0);
    add_item(OP_END, '0, '0, '0, '0, '0);

    // random: mostly whole reports, some broken sequences and raw noise
    while (report_items.size() < RANDOM_ITEMS) begin
      n = $urandom_range(99);
      if (n < 75) begin
        add_item(OP_START, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        repeat ($urandom_range(7)) add_random_field();
        add_item(OP_END, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        if ($urandom_range(9) == 0) add_item(OP_END, '0, '0, '0, '0, '0);
      end else if (n < 90) begin
        // end without start, or a start that is dropped midway
        if ($urandom_range(1) == 0) add_item(OP_START, '0, '0, '0, '0, '0);
        repeat ($urandom_range(3)) add_random_field();
        if ($urandom_range(1) == 0) add_item(OP_START, '0, '0, '0, '0, '0);
        repeat ($urandom_range(3)) add_random_field();
        add_item(OP_END, '0, '0, '0, '0, '0);
      end else begin
        add_item(2'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (report_items.size() != 0 || in_push) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items (%0d on kept usages) with %0d ends of report, %0s %0d",
             items_accepted, useful_items, ends_accepted, "input held off on cycles:",
             full_stalls);
    $display("events checked: %0d (absolute %0d, relative %0d, scroll %0d, button %0d)",
             events_checked, events_by_kind[KIND_ABS], events_by_kind[KIND_REL],
             events_by_kind[KIND_SCROLL], events_by_kind[KIND_BUTTON]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hmre_pkg.sv
rtl/core/hmre_cmdq.sv
rtl/core/hmre_front.sv
rtl/core/hmre_back.sv
rtl/core/hid_mouse_report_to_events.sv
rtl/core/hmre_checker.sv
sim/tb_top.sv
